// ===== design/bbl_pkg.sv =====
package bbl_pkg;

  // Default sizing of the cache
  localparam int SLOTS_DEF     = 16;
  localparam int KEY_BITS_DEF  = 16;
  localparam int SIZE_BITS_DEF = 24;

  // Byte budget after reset
  localparam int unsigned MAX_BYTES_RST = 65536;

  // Operations of the shared byte arithmetic unit
  typedef enum logic {
    ALU_ADD,  // used + size, flag when above budget
    ALU_SUB   // used - size, floored at zero
  } alu_op_t;

  // Commands from the sequencer to the slot array
  typedef struct packed {
    logic capture;  // latch key match vector of a new item
    logic touch;    // make the hit entry most recent
    logic evict;    // drop the least recent entry
    logic insert;   // write the new entry as most recent
  } slot_cmd_t;

  // Status of the slot array
  typedef struct packed {
    logic hit;
    logic full;
    logic empty;
  } slot_stat_t;

endpackage

// ===== design/byte_budget_lru_cache.sv =====
// Steps: an accepted item is looked up; a hit is made most recent and finishes, while a miss
// runs a budget check that either evicts the oldest entry and checks again, inserts, or
// finishes unstored (one budget check and one subtract per eviction through the shared adder).
// One item at a time: the next item is accepted once the result is registered, which waits
// for a free output register. Reset (synchronous, active low) empties the table, zeroes bytes
// in use and sets the budget to 65536; no clearing pass is needed.
module byte_budget_lru_cache import bbl_pkg::*; #(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int KEY_BITS  = KEY_BITS_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // budget register write
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [SIZE_BITS-1:0]       cfg_max_bytes,
  // request items
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [KEY_BITS-1:0]        in_key,
  input  logic [SIZE_BITS-1:0]       in_item_size,
  // result items
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_hit,
  output logic                       out_stored,
  output logic [$clog2(SLOTS+1)-1:0] out_evicted,
  output logic [SIZE_BITS-1:0]       out_bytes_in_use,
  output logic [$clog2(SLOTS+1)-1:0] out_entries_in_use
);

  localparam int CNT_W = $clog2(SLOTS+1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_CHECK,
    ST_EVICT,
    ST_INSERT,
    ST_FINISH
  } state_t;

  state_t               state_r, state_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic [SIZE_BITS-1:0] size_r, size_nxt;
  logic [SIZE_BITS-1:0] used_r, used_nxt;
  logic [SIZE_BITS-1:0] max_r, max_nxt;
  logic [CNT_W-1:0]     evicted_r, evicted_nxt;
  logic                 hit_r, hit_nxt;
  logic                 stored_r, stored_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic                 out_stored_r, out_stored_nxt;
  logic [CNT_W-1:0]     out_evicted_r, out_evicted_nxt;
  logic [SIZE_BITS-1:0] out_bytes_r, out_bytes_nxt;
  logic [CNT_W-1:0]     out_entries_r, out_entries_nxt;

  slot_cmd_t            cmd;
  slot_stat_t           stat;
  logic [SIZE_BITS-1:0] victim_size;
  logic [CNT_W-1:0]     count;
  alu_op_t              alu_op;
  logic [SIZE_BITS-1:0] alu_b;
  logic [SIZE_BITS-1:0] alu_result;
  logic                 alu_over;
  logic                 in_fire;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  bbl_slots #(
    .SLOTS     (SLOTS),
    .KEY_BITS  (KEY_BITS),
    .SIZE_BITS (SIZE_BITS)
  ) u_slots (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .lookup_key  (in_key),
    .ins_key     (key_r),
    .ins_size    (size_r),
    .stat        (stat),
    .victim_size (victim_size),
    .count       (count)
  );

  // Eviction subtracts the victim's size; every other step adds the request size
  assign alu_b = (alu_op == ALU_SUB) ? victim_size : size_r;

  bbl_alu #(
    .SIZE_BITS (SIZE_BITS)
  ) u_alu (
    .op     (alu_op),
    .a      (used_r),
    .b      (alu_b),
    .limit  (max_r),
    .result (alu_result),
    .over   (alu_over)
  );

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    key_nxt         = key_r;
    size_nxt        = size_r;
    used_nxt        = used_r;
    max_nxt         = max_r;
    evicted_nxt     = evicted_r;
    hit_nxt         = hit_r;
    stored_nxt      = stored_r;
    out_valid_nxt   = out_valid_r;
    out_hit_nxt     = out_hit_r;
    out_stored_nxt  = out_stored_r;
    out_evicted_nxt = out_evicted_r;
    out_bytes_nxt   = out_bytes_r;
    out_entries_nxt = out_entries_r;
    cmd             = '0;
    alu_op          = ALU_ADD;

    if (cfg_valid && cfg_ready) begin
      max_nxt = cfg_max_bytes;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.capture = 1'b1;
          key_nxt     = in_key;
          size_nxt    = in_item_size;
          evicted_nxt = '0;
          hit_nxt     = 1'b0;
          stored_nxt  = 1'b0;
          state_nxt   = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (stat.hit) begin
          cmd.touch  = 1'b1;
          hit_nxt    = 1'b1;
          stored_nxt = 1'b1;
          state_nxt  = ST_FINISH;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // with an empty table used is zero, so over means the size alone is too big
        alu_op = ALU_ADD;
        if (alu_over && !stat.empty) begin
          state_nxt = ST_EVICT;
        end else if (alu_over) begin
          state_nxt = ST_FINISH;
        end else if (stat.full) begin
          state_nxt = ST_EVICT;
        end else begin
          state_nxt = ST_INSERT;
        end
      end
      ST_EVICT: begin
        alu_op      = ALU_SUB;
        cmd.evict   = 1'b1;
        used_nxt    = alu_result;
        evicted_nxt = evicted_r + CNT_W'(1);
        state_nxt   = ST_CHECK;
      end
      ST_INSERT: begin
        alu_op     = ALU_ADD;
        cmd.insert = 1'b1;
        used_nxt   = alu_result;
        stored_nxt = 1'b1;
        state_nxt  = ST_FINISH;
      end
      ST_FINISH: begin
        // load the result once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_hit_nxt     = hit_r;
          out_stored_nxt  = stored_r;
          out_evicted_nxt = evicted_r;
          out_bytes_nxt   = used_r;
          out_entries_nxt = count;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      max_r       <= SIZE_BITS'(MAX_BYTES_RST);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r         <= key_nxt;
    size_r        <= size_nxt;
    evicted_r     <= evicted_nxt;
    hit_r         <= hit_nxt;
    stored_r      <= stored_nxt;
    out_hit_r     <= out_hit_nxt;
    out_stored_r  <= out_stored_nxt;
    out_evicted_r <= out_evicted_nxt;
    out_bytes_r   <= out_bytes_nxt;
    out_entries_r <= out_entries_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_stored         = out_stored_r;
  assign out_evicted        = out_evicted_r;
  assign out_bytes_in_use   = out_bytes_r;
  assign out_entries_in_use = out_entries_r;

endmodule

// ===== design/bbl_alu.sv =====
// Shared adder/subtractor with budget compare
module bbl_alu import bbl_pkg::*; #(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  alu_op_t              op,
  input  logic [SIZE_BITS-1:0] a,
  input  logic [SIZE_BITS-1:0] b,
  input  logic [SIZE_BITS-1:0] limit,
  output logic [SIZE_BITS-1:0] result,
  output logic                 over
);

  logic [SIZE_BITS:0] sum;
  logic [SIZE_BITS:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = {1'b0, a} - {1'b0, b};

  always_comb begin
    case (op)
      ALU_ADD: begin
        result = sum[SIZE_BITS-1:0];
        over   = (sum > {1'b0, limit});
      end
      ALU_SUB: begin
        // borrow means the subtrahend was larger: floor at zero
        result = diff[SIZE_BITS] ? '0 : diff[SIZE_BITS-1:0];
        over   = 1'b0;
      end
      default: begin
        result = '0;
        over   = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/bbl_slots.sv =====
// Slot array: per-slot key compare, age tracking, victim and free slot pick
module bbl_slots import bbl_pkg::*; #(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int KEY_BITS  = KEY_BITS_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  slot_cmd_t                  cmd,
  input  logic [KEY_BITS-1:0]        lookup_key,
  input  logic [KEY_BITS-1:0]        ins_key,
  input  logic [SIZE_BITS-1:0]       ins_size,
  output slot_stat_t                 stat,
  output logic [SIZE_BITS-1:0]       victim_size,
  output logic [$clog2(SLOTS+1)-1:0] count
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS+1);

  logic [SLOTS-1:0]     valid_r;
  logic [SLOTS-1:0]     hit_vec_r;
  logic [CNT_W-1:0]     count_r;
  logic [KEY_BITS-1:0]  key_r  [SLOTS];
  logic [SIZE_BITS-1:0] size_r [SLOTS];
  logic [IDX_W-1:0]     age_r  [SLOTS];

  logic [SLOTS-1:0]     match;
  logic [SLOTS-1:0]     victim_vec;
  logic [IDX_W-1:0]     oldest_age;
  logic [IDX_W-1:0]     hit_age;
  logic [IDX_W-1:0]     free_idx;
  logic [CNT_W-1:0]     count_m1;

  assign count_m1   = count_r - CNT_W'(1);
  assign oldest_age = count_m1[IDX_W-1:0];

  // Per-slot compares and one-hot selects
  always_comb begin
    hit_age     = '0;
    victim_size = '0;
    for (int i = 0; i < SLOTS; i++) begin
      match[i]      = valid_r[i] && (key_r[i] == lookup_key);
      victim_vec[i] = valid_r[i] && (age_r[i] == oldest_age);
      hit_age       = hit_age | (hit_vec_r[i] ? age_r[i] : '0);
      victim_size   = victim_size | (victim_vec[i] ? size_r[i] : '0);
    end
  end

  // Lowest-numbered invalid slot
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  // Valid bits, fill count and captured match vector
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      hit_vec_r <= '0;
      count_r   <= '0;
    end else begin
      if (cmd.capture) begin
        hit_vec_r <= match;
      end
      if (cmd.evict) begin
        valid_r <= valid_r & ~victim_vec;
        count_r <= count_m1;
      end else if (cmd.insert) begin
        valid_r[free_idx] <= 1'b1;
        count_r           <= count_r + CNT_W'(1);
      end
    end
  end

  // Slot payload and ages
  always_ff @(posedge clk) begin
    if (cmd.touch) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (hit_vec_r[i]) begin
          age_r[i] <= '0;
        end else if (valid_r[i] && (age_r[i] < hit_age)) begin
          age_r[i] <= age_r[i] + IDX_W'(1);
        end
      end
    end else if (cmd.insert) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (valid_r[i]) begin
          age_r[i] <= age_r[i] + IDX_W'(1);
        end
      end
      key_r[free_idx]  <= ins_key;
      size_r[free_idx] <= ins_size;
      age_r[free_idx]  <= '0;
    end
  end

  assign stat.hit   = |hit_vec_r;
  assign stat.full  = (count_r == CNT_W'(SLOTS));
  assign stat.empty = (count_r == '0);
  assign count      = count_r;

endmodule

// ===== tb/byte_budget_lru_cache_test.sv =====
`timescale 1ns / 100ps

module byte_budget_lru_cache_test import bbl_pkg::*;;

  localparam int SLOTS = SLOTS_DEF;
  localparam int CNT_W = $clog2(SLOTS_DEF + 1);
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned STALL_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 48;

  typedef logic [KEY_BITS_DEF-1:0] key_t;
  typedef logic [SIZE_BITS_DEF-1:0] size_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef struct packed {
    logic   hit;
    logic   stored;
    count_t evicted;
    size_t  bytes_in_use;
    count_t entries_in_use;
  } lookup_result_t;

  logic   clk;
  logic   rst_n;
  logic   cfg_valid;
  logic   cfg_ready;
  size_t  cfg_max_bytes;
  logic   in_valid;
  logic   in_ready;
  key_t   in_key;
  size_t  in_item_size;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic   out_hit;
  logic   out_stored;
  count_t out_evicted;
  size_t  out_bytes_in_use;
  count_t out_entries_in_use;

  byte_budget_lru_cache DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_max_bytes     (cfg_max_bytes),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_key            (in_key),
    .in_item_size      (in_item_size),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_stored        (out_stored),
    .out_evicted       (out_evicted),
    .out_bytes_in_use  (out_bytes_in_use),
    .out_entries_in_use(out_entries_in_use)
  );

  // Shadow copy of the cache table
  logic        cache_valid [SLOTS];
  key_t        cache_key   [SLOTS];
  size_t       cache_size  [SLOTS];
  int unsigned cache_age   [SLOTS];
  size_t       bytes_used;
  count_t      entries_used;
  size_t       budget;

  lookup_result_t expected_q[$];
  int unsigned    items_sent;
  int unsigned    results_checked = 0;
  int unsigned    error_count = 0;
  int unsigned    cycle_count = 0;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  int unsigned    stall_left = 0;
  logic           stall_kick;
  key_t           hot_keys [24];

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns MISMATCH: %s", $time, msg);
    error_count++;
  endtask

  // Drop the entry with the greatest age
  function automatic void drop_oldest();
    int pick;
    pick = -1;
    for (int i = 0; i < SLOTS; i++)
      if (cache_valid[i] && (pick < 0 || cache_age[i] >= cache_age[pick])) pick = i;
    if (pick >= 0) begin
      cache_valid[pick] = 1'b0;
      bytes_used = (bytes_used >= cache_size[pick]) ? bytes_used - cache_size[pick] : '0;
      if (entries_used != 0) entries_used--;
    end
  endfunction

  // Apply one request to the shadow table and return the result it gives
  function automatic lookup_result_t predict_lookup(input key_t key, input size_t size);
    lookup_result_t r;
    int found;
    int free_slot;
    int unsigned age;
    r = '0;
    found = -1;
    free_slot = -1;
    for (int i = 0; i < SLOTS; i++)
      if (found < 0 && cache_valid[i] && cache_key[i] == key) found = i;
    if (found >= 0) begin
      // hit: move to front, size ignored
      age = cache_age[found];
      for (int i = 0; i < SLOTS; i++)
        if (cache_valid[i] && cache_age[i] < age) cache_age[i]++;
      cache_age[found] = 0;
      r.hit = 1'b1;
      r.stored = 1'b1;
    end else begin
      // miss: make room within the budget
      while (entries_used != 0 && {1'b0, bytes_used} + size > budget) begin
        drop_oldest();
        r.evicted++;
      end
      if (size <= budget) begin
        if (entries_used >= SLOTS) begin
          drop_oldest();
          r.evicted++;
        end
        for (int i = 0; i < SLOTS; i++)
          if (free_slot < 0 && !cache_valid[i]) free_slot = i;
        if (free_slot >= 0) begin
          for (int i = 0; i < SLOTS; i++)
            if (cache_valid[i]) cache_age[i]++;
          cache_valid[free_slot] = 1'b1;
          cache_key[free_slot] = key;
          cache_size[free_slot] = size;
          cache_age[free_slot] = 0;
          bytes_used = bytes_used + size;
          entries_used++;
          r.stored = 1'b1;
        end
      end
    end
    r.bytes_in_use = bytes_used;
    r.entries_in_use = entries_used;
    return r;
  endfunction

  // Offer one request item; valid stays up for a following item
  task automatic send_request(input key_t key, input size_t size);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key <= key;
    in_item_size <= size;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(predict_lookup(key, size));
    items_sent++;
  endtask

  // Let every outstanding result come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_checked != items_sent) @(posedge clk);
  endtask

  // Write the byte budget while the block is idle
  task automatic apply_budget(input size_t value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_max_bytes <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    budget = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic key_t pick_key();
    if ($urandom_range(99) < 75) return hot_keys[$urandom_range(0, 23)];
    return key_t'($urandom);
  endfunction

  // Mostly sizes that fit several times over, some extremes and raw noise
  function automatic size_t pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return '0;
    if (r < 7) return '1;
    if (r < 13) return size_t'($urandom);
    if (r < 50) return size_t'($urandom_range(0, budget / 32));
    return size_t'($urandom_range(0, budget / 6));
  endfunction

  // Hits, misses, zero and oversize objects, full table, exact fit
  task automatic test_directed_cases();
    send_request(16'h0000, '0);
    send_request(16'hFFFF, 24'd100);
    send_request(16'h0000, 24'd500);
    send_request(16'h0001, 24'hFFFFFF);
    for (int k = 1; k <= 16; k++) send_request(key_t'(k), 24'd1000);
    send_request(16'd17, 24'd1000);
    send_request(16'd2, 24'd9999);
    send_request(16'd18, 24'd1000);
    send_request(16'h8000, size_t'(MAX_BYTES_RST));
    send_request(16'h1234, '0);
  endtask

  // Budget lowered under the bytes in use, then zero and full-scale budgets
  task automatic test_budget_changes();
    for (int k = 20; k < 24; k++) send_request(key_t'(k), 24'd15000);
    apply_budget(24'd1000);
    send_request(16'd23, 24'd5);
    send_request(16'd30, 24'd10);
    apply_budget('0);
    send_request(16'd40, '0);
    send_request(16'd41, 24'd1);
    send_request(16'd42, '0);
    apply_budget(24'hFFFFFF);
    send_request(16'd50, 24'hFFFFFF);
    send_request(16'd51, 24'd1);
    send_request(16'd52, 24'hFFFFFE);
    apply_budget(size_t'(MAX_BYTES_RST));
  endtask

  // Random requests over two budgets at one idling mix
  task automatic test_random_traffic(input int unsigned s_pct, input int unsigned r_pct,
                                     input size_t budget_a, input size_t budget_b);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    apply_budget(budget_a);
    for (int n = 0; n < 150; n++) send_request(pick_key(), pick_size());
    apply_budget(budget_b);
    for (int n = 0; n < 150; n++) send_request(pick_key(), pick_size());
  endtask

  // Output held off for a long stretch while requests keep coming
  task automatic test_output_stall();
    send_idle_pct = 0;
    stall_kick <= 1'b1;
    @(posedge clk);
    stall_kick <= 1'b0;
    for (int n = 0; n < 12; n++) send_request(pick_key(), pick_size());
  endtask

  // Receiver readiness with random stalls and the long hold-off
  always @(posedge clk) begin
    if (stall_kick || stall_left != 0) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (stall_kick) stall_left <= STALL_CYCLES;
    else if (stall_left != 0) stall_left <= stall_left - 1;
  end

  // Compare each result item with the oldest prediction
  always @(posedge clk) begin : check_results
    lookup_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result item with no request outstanding");
      end else begin
        want = expected_q.pop_front();
        if (out_hit !== want.hit)
          report_mismatch($sformatf("hit got %0b want %0b", out_hit, want.hit));
        if (out_stored !== want.stored)
          report_mismatch($sformatf("stored got %0b want %0b", out_stored, want.stored));
        if (out_evicted !== want.evicted)
          report_mismatch($sformatf("evicted got %0d want %0d", out_evicted, want.evicted));
        if (out_bytes_in_use !== want.bytes_in_use)
          report_mismatch($sformatf("bytes_in_use got %0d want %0d",
                                    out_bytes_in_use, want.bytes_in_use));
        if (out_entries_in_use !== want.entries_in_use)
          report_mismatch($sformatf("entries_in_use got %0d want %0d",
                                    out_entries_in_use, want.entries_in_use));
      end
      results_checked++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_max_bytes <= '0;
    in_valid <= 1'b0;
    in_key <= '0;
    in_item_size <= '0;
    stall_kick <= 1'b0;
    items_sent = 0;
    send_idle_pct = 26;
    recv_idle_pct = 80;

    // shadow table after reset
    for (int i = 0; i < SLOTS; i++) begin
      cache_valid[i] = 1'b0;
      cache_key[i] = '0;
      cache_size[i] = '0;
      cache_age[i] = 0;
    end
    bytes_used = '0;
    entries_used = '0;
    budget = size_t'(MAX_BYTES_RST);

    // small working set so hits are frequent, corner keys included
    hot_keys[0] = '0;
    hot_keys[1] = '1;
    for (int i = 2; i < 24; i++) hot_keys[i] = key_t'($urandom);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_budget_changes();
    test_random_traffic(26, 80, 24'd4096, 24'hFFFFFF);
    test_random_traffic(80, 26, size_t'($urandom_range(512, 65536)), 24'd300000);
    test_output_stall();
    test_random_traffic(0, 0, size_t'(MAX_BYTES_RST), size_t'($urandom));

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
